### design/edpe_pkg.sv
// ----------------------------------------------------------------------------
// edpe_pkg
// Shared types, constants and the escape group width table of the
// escape-delta position encoder.
// ----------------------------------------------------------------------------
package edpe_pkg;

    localparam int unsigned POS_W     = 8;
    localparam int unsigned WIDTH_W   = 4;
    localparam int unsigned BITS_W    = 16;
    localparam int unsigned ENTRY_W   = 8;
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned GROUP_COUNT = 12;

    localparam logic [POS_W-1:0]   POS_START = {POS_W{1'b1}};
    localparam logic [ENTRY_W-1:0] ENTRY_MAX = {ENTRY_W{1'b1}};
    localparam logic [BITS_W-1:0]  BITS_MAX  = {BITS_W{1'b1}};

    // Result of one pass of the shared group unit.
    typedef struct packed {
        logic [POS_W-1:0]   value;
        logic [WIDTH_W-1:0] width;
        logic               last;
        logic [POS_W-1:0]   gap_rem;
        logic [BITS_W-1:0]  bits;
    } group_res_t;

    // Width of each escape group in a run.
    function automatic logic [WIDTH_W-1:0] group_width(input logic [STEP_W-1:0] step);
        logic [WIDTH_W-1:0] w;
        case (step)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: w = 4'd1;
            4'd6, 4'd7, 4'd8:                   w = 4'd2;
            4'd9:                               w = 4'd3;
            4'd10:                              w = 4'd4;
            4'd11:                              w = 4'd8;
            default:                            w = 4'd8;
        endcase
        return w;
    endfunction

    // Largest value a group of the given step can carry, 2^w - 1.
    function automatic logic [POS_W-1:0] group_limit(input logic [STEP_W-1:0] step);
        logic [POS_W-1:0] lim;
        case (step)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: lim = 8'd1;
            4'd6, 4'd7, 4'd8:                   lim = 8'd3;
            4'd9:                               lim = 8'd7;
            4'd10:                              lim = 8'd15;
            4'd11:                              lim = 8'd255;
            default:                            lim = 8'd255;
        endcase
        return lim;
    endfunction

endpackage

### design/edpe_in_if.sv
// ----------------------------------------------------------------------------
// edpe_in_if
// Valid/ready channel carrying one pixel position word.
// ----------------------------------------------------------------------------
interface edpe_in_if;
    logic                      valid;
    logic                      ready;
    logic [edpe_pkg::POS_W-1:0] position;
    logic                      restart;

    modport source (output valid, output position, output restart, input ready);
    modport sink   (input valid, input position, input restart, output ready);
endinterface

### design/edpe_out_if.sv
// ----------------------------------------------------------------------------
// edpe_out_if
// Valid/ready channel carrying one escape group word.
// ----------------------------------------------------------------------------
interface edpe_out_if;
    logic                          valid;
    logic                          ready;
    logic [edpe_pkg::POS_W-1:0]    code_value;
    logic [edpe_pkg::WIDTH_W-1:0]  code_width;
    logic                          last_group;
    logic [edpe_pkg::BITS_W-1:0]   total_bits;
    logic [edpe_pkg::ENTRY_W-1:0]  entries_coded;

    modport source (output valid, output code_value, output code_width,
                    output last_group, output total_bits, output entries_coded,
                    input ready);
    modport sink   (input valid, input code_value, input code_width,
                    input last_group, input total_bits, input entries_coded,
                    output ready);
endinterface

### design/edpe_group_unit.sv
// ----------------------------------------------------------------------------
// edpe_group_unit
// Compare, subtract and saturating bit count for one escape group.
// ----------------------------------------------------------------------------
module edpe_group_unit (
    input  logic [edpe_pkg::STEP_W-1:0] step,
    input  logic [edpe_pkg::POS_W-1:0]  gap,
    input  logic [edpe_pkg::BITS_W-1:0] bits,
    output edpe_pkg::group_res_t        res
);

    logic [edpe_pkg::POS_W-1:0]  limit;
    logic [edpe_pkg::BITS_W:0]   bits_sum;

    always_comb
    begin
        limit    = edpe_pkg::group_limit(step);
        res.width = edpe_pkg::group_width(step);
        bits_sum = {1'b0, bits} + {{(edpe_pkg::BITS_W+1-edpe_pkg::WIDTH_W){1'b0}}, res.width};
        res.bits = bits_sum[edpe_pkg::BITS_W] ? edpe_pkg::BITS_MAX
                                              : bits_sum[edpe_pkg::BITS_W-1:0];
        if (gap <= limit)
        begin
            res.value   = gap;
            res.last    = 1'b1;
            res.gap_rem = '0;
        end
        else
        begin
            res.value   = '0;
            res.last    = 1'b0;
            res.gap_rem = gap - limit;
        end
    end

endmodule

### design/escape_delta_position_encoder.sv
// ----------------------------------------------------------------------------
// escape_delta_position_encoder
// Codes the gap between successive lit-pixel positions as a run of escape
// groups of widths 1,1,1,1,1,1,2,2,2,3,4,8.
// ----------------------------------------------------------------------------
//
//  Channel      Role   Word
//  position_ch  sink   position (8), restart (1)
//  code_ch      source code_value (8), code_width (4), last_group (1),
//                      total_bits (16), entries_coded (8)
//
// A position word is taken while the sequencer is idle. A gap that needs
// N groups (1 to 12) then keeps the block busy, one group a cycle through
// the single shared group unit whenever the output register can take it;
// a zero gap yields no word and leaves the sequencer idle.
// Reset sets the previous position to 255 and clears both counters.
// When code_ch stalls, the held group word stays in the output register and
// the sequencer waits; a new position may be taken once the final group of
// the run has been loaded, even if that group has not yet been taken.
module escape_delta_position_encoder (
    input  logic               clk,
    input  logic               rst_n,
    edpe_in_if.sink            position_ch,
    edpe_out_if.source         code_ch
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t                        state_reg, state_next;
    logic [edpe_pkg::POS_W-1:0]    prev_reg, prev_next;
    logic [edpe_pkg::BITS_W-1:0]   bits_reg, bits_next;
    logic [edpe_pkg::ENTRY_W-1:0]  entry_reg, entry_next;
    logic [edpe_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [edpe_pkg::POS_W-1:0]    gap_reg, gap_next;

    // Output register.
    logic                          ovalid_reg, ovalid_next;
    logic [edpe_pkg::POS_W-1:0]    ovalue_reg, ovalue_next;
    logic [edpe_pkg::WIDTH_W-1:0]  owidth_reg, owidth_next;
    logic                          olast_reg, olast_next;
    logic [edpe_pkg::BITS_W-1:0]   obits_reg, obits_next;
    logic [edpe_pkg::ENTRY_W-1:0]  oentry_reg, oentry_next;

    edpe_pkg::group_res_t          group_res;
    logic                          in_take;
    logic                          out_free;
    logic [edpe_pkg::POS_W-1:0]    prev_base;
    logic [edpe_pkg::ENTRY_W-1:0]  entry_base;
    logic [edpe_pkg::POS_W-1:0]    gap_new;

    edpe_group_unit u_group (
        .step (step_reg),
        .gap  (gap_reg),
        .bits (bits_reg),
        .res  (group_res)
    );

    assign position_ch.ready = (state_reg == ST_IDLE);
    assign in_take  = position_ch.valid && position_ch.ready;
    assign out_free = !ovalid_reg || code_ch.ready;

    assign code_ch.valid         = ovalid_reg;
    assign code_ch.code_value    = ovalue_reg;
    assign code_ch.code_width    = owidth_reg;
    assign code_ch.last_group    = olast_reg;
    assign code_ch.total_bits    = obits_reg;
    assign code_ch.entries_coded = oentry_reg;

    // A restart acts before the gap is formed.
    assign prev_base  = position_ch.restart ? edpe_pkg::POS_START : prev_reg;
    assign entry_base = position_ch.restart ? '0 : entry_reg;
    assign gap_new    = position_ch.position - prev_base;

    always_comb
    begin
        state_next  = state_reg;
        prev_next   = prev_reg;
        bits_next   = bits_reg;
        entry_next  = entry_reg;
        step_next   = step_reg;
        gap_next    = gap_reg;
        ovalid_next = ovalid_reg;
        ovalue_next = ovalue_reg;
        owidth_next = owidth_reg;
        olast_next  = olast_reg;
        obits_next  = obits_reg;
        oentry_next = oentry_reg;

        if (ovalid_reg && code_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    prev_next  = position_ch.position;
                    entry_next = (entry_base == edpe_pkg::ENTRY_MAX) ? entry_base
                                                                     : entry_base + 1'b1;
                    if (position_ch.restart)
                    begin
                        bits_next = '0;
                    end
                    gap_next  = gap_new;
                    step_next = '0;
                    if (gap_new != '0)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                // One group per cycle whenever the output register can take it.
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ovalue_next = group_res.value;
                    owidth_next = group_res.width;
                    olast_next  = group_res.last;
                    obits_next  = group_res.bits;
                    oentry_next = entry_reg;
                    bits_next   = group_res.bits;
                    gap_next    = group_res.gap_rem;
                    step_next   = step_reg + 1'b1;
                    if (group_res.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            prev_reg   <= edpe_pkg::POS_START;
            bits_reg   <= '0;
            entry_reg  <= '0;
            step_reg   <= '0;
            gap_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            prev_reg   <= prev_next;
            bits_reg   <= bits_next;
            entry_reg  <= entry_next;
            step_reg   <= step_next;
            gap_reg    <= gap_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovalue_reg <= ovalue_next;
        owidth_reg <= owidth_next;
        olast_reg  <= olast_next;
        obits_reg  <= obits_next;
        oentry_reg <= oentry_next;
    end

endmodule
